/* rtl/core/clcw_pkg.sv */
// ----------------------------------------------------------------------------
// clcw_pkg
// Shared types, constants and helpers for the character-LCD cursor writer.
// ----------------------------------------------------------------------------
package clcw_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COL_W     = 6;
    localparam int unsigned ROW_W     = 2;
    localparam int unsigned TAB_W     = 4;
    localparam int unsigned BASE_W    = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STEP_W    = 3;

    // default number of display rows
    localparam int unsigned ROWS = 4;

    // entries in the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_BASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3_BASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_WORD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WORD  = 3'd6;

    // register reset values
    localparam logic [COL_W-1:0]  RST_COLUMNS       = 6'd20;
    localparam logic [TAB_W-1:0]  RST_TAB_STEP      = 4'd2;
    localparam logic [BASE_W-1:0] RST_ROW1_BASE     = 7'h40;
    localparam logic [BASE_W-1:0] RST_ROW2_BASE     = 7'h14;
    localparam logic [BASE_W-1:0] RST_ROW3_BASE     = 7'h54;
    localparam logic [BYTE_W-1:0] RST_FUNCTION_WORD = 8'd56;
    localparam logic [BYTE_W-1:0] RST_DISPLAY_WORD  = 8'h0F;

    // LCD command bytes and special characters
    localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_ENTRY    = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;

    // register select codes
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // init sequence steps
    localparam logic [STEP_W-1:0] STEP_FIRST_BUSY = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CLEAR      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DISPLAY    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ENTRY      = 3'd6;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        JOB_INIT      = 2'd0,
        JOB_DATA      = 2'd1,
        JOB_DATA_ADDR = 2'd2,
        JOB_ADDR      = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] addr_cmd;
    } t_job;

    typedef struct packed {
        logic [COL_W-1:0]  columns;
        logic [TAB_W-1:0]  tab_step;
        logic [BASE_W-1:0] row1_base;
        logic [BASE_W-1:0] row2_base;
        logic [BASE_W-1:0] row3_base;
        logic [BYTE_W-1:0] function_word;
        logic [BYTE_W-1:0] display_word;
    } t_cfg;

    // display address of column 0 of a row; row 0 sits at address 0
    function automatic logic [BASE_W-1:0] row_base(input t_cfg cfg,
                                                   input logic [ROW_W-1:0] row);
        logic [BASE_W-1:0] base;
        case (row)
            2'd1: base = cfg.row1_base;
            2'd2: base = cfg.row2_base;
            2'd3: base = cfg.row3_base;
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

/* rtl/core/clcw_char_if.sv */
// ----------------------------------------------------------------------------
// clcw_char_if
// Character channel: one item is an action and a character byte.
// ----------------------------------------------------------------------------
interface clcw_char_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [clcw_pkg::BYTE_W-1:0]  char_code;

    modport source (output valid, output action, output char_code, input ready);
    modport sink   (input valid, input action, input char_code, output ready);
endinterface

/* rtl/core/clcw_bus_if.sv */
// ----------------------------------------------------------------------------
// clcw_bus_if
// LCD bus write channel: one item is one register write on the LCD bus.
// ----------------------------------------------------------------------------
interface clcw_bus_if;
    logic                         valid;
    logic                         ready;
    logic                         reg_select;
    logic [clcw_pkg::BYTE_W-1:0]  bus_byte;
    logic                         check_busy;
    logic                         last;

    modport source (output valid, output reg_select, output bus_byte,
                    output check_busy, output last, input ready);
    modport sink   (input valid, input reg_select, input bus_byte,
                    input check_busy, input last, output ready);
endinterface

/* rtl/core/clcw_front.sv */
// ----------------------------------------------------------------------------
// clcw_front
// Accepts character items, tracks the cursor and classifies each item into
// a job for the bus sequencer, with the set-address command worked out.
// ----------------------------------------------------------------------------
module clcw_front #(
    parameter int unsigned ROWS = clcw_pkg::ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  clcw_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    input  logic                  i_action,
    input  logic [clcw_pkg::BYTE_W-1:0] i_char_code,
    output logic                  o_ready,
    output logic                  o_push,
    output clcw_pkg::t_job        o_job,
    input  logic                  i_queue_full
);

    localparam logic [clcw_pkg::ROW_W:0] LP_ROWS = (clcw_pkg::ROW_W+1)'(ROWS);

    logic [clcw_pkg::COL_W-1:0] r_col, n_col;
    logic [clcw_pkg::ROW_W-1:0] r_row, n_row;

    logic [clcw_pkg::ROW_W:0]   row_inc;
    logic [clcw_pkg::ROW_W-1:0] row_next;
    logic [clcw_pkg::COL_W:0]   col_plus_one;
    logic [clcw_pkg::COL_W:0]   col_plus_tab;
    logic [clcw_pkg::COL_W:0]   columns_ext;
    logic [clcw_pkg::COL_W:0]   tab_ext;
    logic [clcw_pkg::BASE_W-1:0] addr_sum;
    clcw_pkg::t_job_kind        job_kind;
    logic                       accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // row advance wraps after the last row
    assign row_inc  = {1'b0, r_row} + (clcw_pkg::ROW_W+1)'(1);
    assign row_next = (row_inc >= LP_ROWS) ? '0 : row_inc[clcw_pkg::ROW_W-1:0];

    assign columns_ext  = {1'b0, i_cfg.columns};
    assign tab_ext      = (clcw_pkg::COL_W+1)'(i_cfg.tab_step);
    assign col_plus_one = {1'b0, r_col} + (clcw_pkg::COL_W+1)'(1);
    assign col_plus_tab = {1'b0, r_col} + tab_ext;

    // classify the item and move the cursor
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        job_kind = clcw_pkg::JOB_DATA;
        if (i_action) begin
            n_col    = '0;
            n_row    = '0;
            job_kind = clcw_pkg::JOB_INIT;
        end else if (i_char_code == clcw_pkg::CH_NEWLINE) begin
            n_col    = '0;
            n_row    = row_next;
            job_kind = clcw_pkg::JOB_ADDR;
        end else if (i_char_code == clcw_pkg::CH_TAB) begin
            job_kind = clcw_pkg::JOB_ADDR;
            if (col_plus_tab < columns_ext) begin
                n_col = col_plus_tab[clcw_pkg::COL_W-1:0];
            end else begin
                n_row = row_next;
                n_col = (tab_ext < columns_ext) ? tab_ext[clcw_pkg::COL_W-1:0] : '0;
            end
        end else if (col_plus_one >= columns_ext) begin
            // printable that fills the row
            n_col    = '0;
            n_row    = row_next;
            job_kind = clcw_pkg::JOB_DATA_ADDR;
        end else begin
            n_col = col_plus_one[clcw_pkg::COL_W-1:0];
        end
    end

    // set-address command for the new cursor, modulo 128
    assign addr_sum = clcw_pkg::row_base(i_cfg, n_row) + clcw_pkg::BASE_W'(n_col);
    assign o_job    = '{kind:      job_kind,
                        char_code: i_char_code,
                        addr_cmd:  clcw_pkg::CMD_SET_ADDR | {1'b0, addr_sum}};

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* rtl/core/clcw_queue.sv */
// ----------------------------------------------------------------------------
// clcw_queue
// Short job queue between the front and the bus sequencer.
// ----------------------------------------------------------------------------
module clcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcw_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output clcw_pkg::t_job o_head
);

    localparam int unsigned PTR_W = (clcw_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(clcw_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(clcw_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LP_DEPTH = CNT_W'(clcw_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LP_LAST  = PTR_W'(clcw_pkg::QUEUE_DEPTH - 1);

    clcw_pkg::t_job     r_mem [clcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == LP_DEPTH);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LP_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LP_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/clcw_back.sv */
// ----------------------------------------------------------------------------
// clcw_back
// Bus sequencer: walks each job through its LCD writes, one per cycle while
// the bus is ready, into an output register.
// ----------------------------------------------------------------------------
module clcw_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  clcw_pkg::t_cfg        i_cfg,
    input  logic                  i_empty,
    input  clcw_pkg::t_job        i_head,
    output logic                  o_pop,
    clcw_bus_if.source            o_bus
);

    logic [clcw_pkg::STEP_W-1:0] r_step;
    logic                        r_valid;
    logic                        r_rs;
    logic [clcw_pkg::BYTE_W-1:0] r_byte;
    logic                        r_busy;
    logic                        r_last;

    logic                        w_rs;
    logic [clcw_pkg::BYTE_W-1:0] w_byte;
    logic                        w_busy;
    logic                        w_last;
    logic                        load;

    assign load  = !i_empty && (!r_valid || o_bus.ready);
    assign o_pop = load && w_last;

    // write produced by the current step of the head job
    always_comb begin
        w_rs   = clcw_pkg::RS_COMMAND;
        w_byte = i_head.addr_cmd;
        w_busy = 1'b1;
        w_last = 1'b1;
        case (i_head.kind)
            clcw_pkg::JOB_INIT: begin
                w_busy = (r_step >= clcw_pkg::STEP_FIRST_BUSY);
                w_last = (r_step == clcw_pkg::STEP_ENTRY);
                case (r_step)
                    clcw_pkg::STEP_CLEAR:   w_byte = clcw_pkg::CMD_CLEAR;
                    clcw_pkg::STEP_DISPLAY: w_byte = i_cfg.display_word;
                    clcw_pkg::STEP_ENTRY:   w_byte = clcw_pkg::CMD_ENTRY;
                    default:                w_byte = i_cfg.function_word;
                endcase
            end
            clcw_pkg::JOB_DATA: begin
                w_rs   = clcw_pkg::RS_DATA;
                w_byte = i_head.char_code;
            end
            clcw_pkg::JOB_DATA_ADDR: begin
                if (r_step == '0) begin
                    w_rs   = clcw_pkg::RS_DATA;
                    w_byte = i_head.char_code;
                    w_last = 1'b0;
                end
            end
            default: begin
                w_byte = i_head.addr_cmd;
            end
        endcase
    end

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= w_last ? '0 : r_step + clcw_pkg::STEP_W'(1);
                r_valid <= 1'b1;
            end else if (o_bus.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs   <= w_rs;
            r_byte <= w_byte;
            r_busy <= w_busy;
            r_last <= w_last;
        end
    end

    assign o_bus.valid      = r_valid;
    assign o_bus.reg_select = r_rs;
    assign o_bus.bus_byte   = r_byte;
    assign o_bus.check_busy = r_busy;
    assign o_bus.last       = r_last;

endmodule

/* rtl/core/char_lcd_cursor_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_cursor_writer
// Turns a text stream into character-LCD bus writes while tracking the
// cursor over up to four rows.
//
//  channel   dir  handshake     payload
//  i_char    in   valid/ready   action, char_code
//  o_bus     out  valid/ready   reg_select, bus_byte, check_busy, last
//  cfg       in   i_cfg_we      i_cfg_index, i_cfg_data
//
// An item is taken whenever the two-entry job queue has room. The bus
// sequencer gives one write per cycle while the bus is ready: a plain
// character or cursor move is one write, a wrapping character two,
// initialisation seven. Each item passes the queue and output register before
// its first write. Synchronous reset clears cursor and queue and presets
// the settings; a stalled bus holds the output and backs up into the queue.
// ----------------------------------------------------------------------------
module char_lcd_cursor_writer #(
    parameter int unsigned ROWS = clcw_pkg::ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [clcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clcw_pkg::BYTE_W-1:0]     i_cfg_data,
    clcw_char_if.sink                       i_char,
    clcw_bus_if.source                      o_bus
);

    clcw_pkg::t_cfg r_cfg;
    clcw_pkg::t_job front_job;
    clcw_pkg::t_job head_job;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    logic           front_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns       <= clcw_pkg::RST_COLUMNS;
            r_cfg.tab_step      <= clcw_pkg::RST_TAB_STEP;
            r_cfg.row1_base     <= clcw_pkg::RST_ROW1_BASE;
            r_cfg.row2_base     <= clcw_pkg::RST_ROW2_BASE;
            r_cfg.row3_base     <= clcw_pkg::RST_ROW3_BASE;
            r_cfg.function_word <= clcw_pkg::RST_FUNCTION_WORD;
            r_cfg.display_word  <= clcw_pkg::RST_DISPLAY_WORD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clcw_pkg::CFG_COLUMNS:
                    r_cfg.columns <= i_cfg_data[clcw_pkg::COL_W-1:0];
                clcw_pkg::CFG_TAB_STEP:
                    r_cfg.tab_step <= i_cfg_data[clcw_pkg::TAB_W-1:0];
                clcw_pkg::CFG_ROW1_BASE:
                    r_cfg.row1_base <= i_cfg_data[clcw_pkg::BASE_W-1:0];
                clcw_pkg::CFG_ROW2_BASE:
                    r_cfg.row2_base <= i_cfg_data[clcw_pkg::BASE_W-1:0];
                clcw_pkg::CFG_ROW3_BASE:
                    r_cfg.row3_base <= i_cfg_data[clcw_pkg::BASE_W-1:0];
                clcw_pkg::CFG_FUNCTION_WORD:
                    r_cfg.function_word <= i_cfg_data;
                clcw_pkg::CFG_DISPLAY_WORD:
                    r_cfg.display_word <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_char.ready = front_ready;

    // cursor tracking and classification
    clcw_front #(
        .ROWS (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_char.valid),
        .i_action     (i_char.action),
        .i_char_code  (i_char.char_code),
        .o_ready      (front_ready),
        .o_push       (push),
        .o_job        (front_job),
        .i_queue_full (queue_full)
    );

    // job queue
    clcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_job)
    );

    // bus write sequencer
    clcw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (queue_empty),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_bus   (o_bus)
    );

endmodule
